/* sv/rrgc_pkg.sv */
package rrgc_pkg;

    localparam int SENSOR_COUNT   = 8;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;   // signed, spans -1.0 .. +1.0
    localparam int ROM_W          = TRIG_FRAC_BITS + 1;   // magnitude, 0 .. 1.0
    localparam int ROM_DEPTH      = 91;                   // 0 .. 90 degrees

    localparam int POS_W  = 32;
    localparam int DIST_W = 24;
    localparam int CPM_W  = 24;
    localparam int GRID_W = 8;
    localparam int DEG_W  = 9;
    localparam int IDX_W  = 3;
    localparam int MQ_W   = POS_W + 1;
    localparam int CELL_W = MQ_W + CPM_W + 1 - 32;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic [1:0] {
        REG_CELLS_PER_METER = 2'd0,
        REG_RANGE_LIMIT     = 2'd1,
        REG_GRID_LIMIT      = 2'd2,
        REG_SENSOR_SPACING  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CPM_W-1:0]  cells_per_meter;
        logic [DIST_W-1:0] range_limit;
        logic [GRID_W-1:0] grid_limit;
        logic [DEG_W-1:0]  sensor_spacing;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [DIST_W-1:0]       span;
    } item_t;

    // sin(k deg), k in 0..90, by a truncated Taylor series in Q30, rounded to
    // Q1.TRIG_FRAC_BITS. Evaluated at elaboration to build the constant table.
    function automatic logic [ROM_W-1:0] sin_rom_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        int unsigned        n;
        x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (n = 1; n <= 7; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > signed'(ONE_Q30))
            sum = signed'(ONE_Q30);
        v = unsigned'(sum);
        v = (v + (64'd1 << (30 - TRIG_FRAC_BITS - 1))) >> (30 - TRIG_FRAC_BITS);
        return v[ROM_W-1:0];
    endfunction

endpackage

/* sv/range_reading_to_grid_cell.sv */
// Range reading to grid cell.
// Input words carry one range reading (robot_x, robot_y, heading_deg,
// sensor_index, distance) on a valid/ready channel; output words carry one
// grid cell (cell_x, cell_y) on a second valid/ready channel.
// A reading whose distance is not below range_limit, or whose cell falls
// outside the open interval (0, grid_limit) on either axis, produces no word.
// The datapath is an eight-stage pipeline: beam angle, quotient by 360,
// remainder, sine/cosine table, distance times trig, offset and floor,
// scale by cells_per_meter, bounds check into the output register. One
// reading is taken every cycle while the pipeline is not held.
// When the receiver holds out_ready low with a word waiting, the whole
// pipeline holds and in_ready drops in the same cycle; nothing is lost.
// Reset empties the pipeline and loads the registers with their defaults.
// Registers sit on the APB port at byte addresses 0x0 cells_per_meter,
// 0x4 range_limit, 0x8 grid_limit, 0xC sensor_spacing; change them only
// while the pipeline is empty.
module range_reading_to_grid_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rrgc_pkg::POS_W-1:0]  robot_x,
    input  logic signed [rrgc_pkg::POS_W-1:0]  robot_y,
    input  logic [rrgc_pkg::DEG_W-1:0]         heading_deg,
    input  logic [rrgc_pkg::IDX_W-1:0]         sensor_index,
    input  logic [rrgc_pkg::DIST_W-1:0]        distance,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rrgc_pkg::GRID_W-1:0]        cell_x,
    output logic [rrgc_pkg::GRID_W-1:0]        cell_y
);

    localparam int VLD_N = 7;
    localparam int DLY_N = 4;

    rrgc_pkg::cfg_t cfg;
    logic           en;

    logic [VLD_N-1:0]                   vld_reg, vld_next;
    rrgc_pkg::item_t                    pay_reg [DLY_N];
    logic                               out_valid_reg, out_valid_next;
    logic [rrgc_pkg::GRID_W-1:0]        cell_x_reg, cell_y_reg;

    logic signed [rrgc_pkg::TRIG_W-1:0] cos_q, sin_q;
    logic signed [rrgc_pkg::CELL_W-1:0] cx, cy;
    logic signed [rrgc_pkg::CELL_W-1:0] gl;
    logic                               keep;
    logic                               take;

    rrgc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // advance everything unless a finished word is being held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign take     = in_valid && (int'(sensor_index) < rrgc_pkg::SENSOR_COUNT) &&
                      (distance < cfg.range_limit);

    rrgc_angle u_angle
    (
        .clk            (clk),
        .en             (en),
        .sensor_index   (sensor_index),
        .heading_deg    (heading_deg),
        .sensor_spacing (cfg.sensor_spacing),
        .cos_q          (cos_q),
        .sin_q          (sin_q)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0].x    <= robot_x;
            pay_reg[0].y    <= robot_y;
            pay_reg[0].span <= distance;
            for (int i = 1; i < DLY_N; i++)
            begin
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    rrgc_proj u_proj_x
    (
        .clk             (clk),
        .en              (en),
        .pos             (pay_reg[DLY_N-1].x),
        .span            (pay_reg[DLY_N-1].span),
        .trig            (cos_q),
        .cells_per_meter (cfg.cells_per_meter),
        .coord           (cx)
    );

    rrgc_proj u_proj_y
    (
        .clk             (clk),
        .en              (en),
        .pos             (pay_reg[DLY_N-1].y),
        .span            (pay_reg[DLY_N-1].span),
        .trig            (sin_q),
        .cells_per_meter (cfg.cells_per_meter),
        .coord           (cy)
    );

    always_comb
    begin
        gl   = signed'(rrgc_pkg::CELL_W'(cfg.grid_limit));
        keep = (cx > 0) && (cx < gl) && (cy > 0) && (cy < gl);

        // drop readings out of range right away; they travel as bubbles
        vld_next       = {vld_reg[VLD_N-2:0], take};
        out_valid_next = vld_reg[VLD_N-1] && keep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_x_reg <= cx[rrgc_pkg::GRID_W-1:0];
            cell_y_reg <= cy[rrgc_pkg::GRID_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_x    = cell_x_reg;
    assign cell_y    = cell_y_reg;

endmodule

/* sv/rrgc_cfg.sv */
module rrgc_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output rrgc_pkg::cfg_t      cfg
);

    rrgc_pkg::cfg_t     cfg_reg;
    rrgc_pkg::cfg_t     cfg_next;
    rrgc_pkg::reg_idx_t sel;
    logic               wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign sel    = rrgc_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (sel)
                rrgc_pkg::REG_CELLS_PER_METER:
                    cfg_next.cells_per_meter = pwdata[rrgc_pkg::CPM_W-1:0];
                rrgc_pkg::REG_RANGE_LIMIT:
                    cfg_next.range_limit = pwdata[rrgc_pkg::DIST_W-1:0];
                rrgc_pkg::REG_GRID_LIMIT:
                    cfg_next.grid_limit = pwdata[rrgc_pkg::GRID_W-1:0];
                rrgc_pkg::REG_SENSOR_SPACING:
                    cfg_next.sensor_spacing = pwdata[rrgc_pkg::DEG_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cells_per_meter <= rrgc_pkg::CPM_W'(65536);
            cfg_reg.range_limit     <= rrgc_pkg::DIST_W'(163840);
            cfg_reg.grid_limit      <= rrgc_pkg::GRID_W'(50);
            cfg_reg.sensor_spacing  <= rrgc_pkg::DEG_W'(45);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (sel)
            rrgc_pkg::REG_CELLS_PER_METER:
                prdata = 32'(cfg_reg.cells_per_meter);
            rrgc_pkg::REG_RANGE_LIMIT:
                prdata = 32'(cfg_reg.range_limit);
            rrgc_pkg::REG_GRID_LIMIT:
                prdata = 32'(cfg_reg.grid_limit);
            rrgc_pkg::REG_SENSOR_SPACING:
                prdata = 32'(cfg_reg.sensor_spacing);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* sv/rrgc_angle.sv */
module rrgc_angle
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [rrgc_pkg::IDX_W-1:0]          sensor_index,
    input  logic [rrgc_pkg::DEG_W-1:0]          heading_deg,
    input  logic [rrgc_pkg::DEG_W-1:0]          sensor_spacing,
    output logic signed [rrgc_pkg::TRIG_W-1:0]  cos_q,
    output logic signed [rrgc_pkg::TRIG_W-1:0]  sin_q
);

    localparam int SUM_W  = 12;   // 7 * 511 + 511 fits
    localparam int QUO_W  = 4;    // quotient by 360 stays below 12
    localparam int REM_W  = 10;   // remainder before correction stays below 720
    localparam int ROM_IW = 7;

    typedef struct packed {
        logic              neg;
        logic [ROM_IW-1:0] idx;
    } rom_sel_t;

    logic [rrgc_pkg::ROM_W-1:0] rom [rrgc_pkg::ROM_DEPTH];

    for (genvar g = 0; g < rrgc_pkg::ROM_DEPTH; g++)
    begin : g_rom
        assign rom[g] = rrgc_pkg::sin_rom_entry(g);
    end

    logic [SUM_W-1:0]                sum_reg, sum_next;
    logic [SUM_W-1:0]                sum_d_reg;
    logic [QUO_W-1:0]                quo_reg, quo_next;
    logic [rrgc_pkg::DEG_W-1:0]      ang_reg, ang_next;
    logic signed [rrgc_pkg::TRIG_W-1:0] cos_reg, cos_next;
    logic signed [rrgc_pkg::TRIG_W-1:0] sin_reg, sin_next;

    logic [SUM_W+8-1:0]         prod;
    logic [REM_W-1:0]           rem;
    logic [REM_W-1:0]           cang_full;
    logic [rrgc_pkg::DEG_W-1:0] cang;
    rom_sel_t                   sel_c;
    rom_sel_t                   sel_s;

    // fold an angle in 0..359 onto the first quadrant
    function automatic rom_sel_t quad_map(input logic [rrgc_pkg::DEG_W-1:0] a);
        rom_sel_t r;
        if (a < rrgc_pkg::DEG_W'(90))
        begin
            r.neg = 1'b0;
            r.idx = ROM_IW'(a);
        end
        else if (a < rrgc_pkg::DEG_W'(180))
        begin
            r.neg = 1'b0;
            r.idx = ROM_IW'(rrgc_pkg::DEG_W'(180) - a);
        end
        else if (a < rrgc_pkg::DEG_W'(270))
        begin
            r.neg = 1'b1;
            r.idx = ROM_IW'(a - rrgc_pkg::DEG_W'(180));
        end
        else
        begin
            r.neg = 1'b1;
            r.idx = ROM_IW'(rrgc_pkg::DEG_W'(360) - a);
        end
        return r;
    endfunction

    function automatic logic signed [rrgc_pkg::TRIG_W-1:0] apply_sign(
        input logic [rrgc_pkg::ROM_W-1:0] mag,
        input logic                       neg
    );
        logic signed [rrgc_pkg::TRIG_W-1:0] v;
        v = signed'({1'b0, mag});
        return neg ? -v : v;
    endfunction

    always_comb
    begin
        sum_next = SUM_W'(sensor_index) * SUM_W'(sensor_spacing) + SUM_W'(heading_deg);

        // divide by 360 through the reciprocal 182 / 2^16; may fall one short
        prod     = (SUM_W + 8)'(sum_reg) * (SUM_W + 8)'(182);
        quo_next = prod[16 +: QUO_W];

        rem = REM_W'(sum_d_reg - SUM_W'(quo_reg) * SUM_W'(360));
        if (rem >= REM_W'(360))
            rem = rem - REM_W'(360);
        ang_next = rrgc_pkg::DEG_W'(rem);

        cang_full = REM_W'(ang_reg) + REM_W'(90);
        if (cang_full >= REM_W'(360))
            cang_full = cang_full - REM_W'(360);
        cang = rrgc_pkg::DEG_W'(cang_full);

        sel_c    = quad_map(cang);
        sel_s    = quad_map(ang_reg);
        cos_next = apply_sign(rom[sel_c.idx], sel_c.neg);
        sin_next = apply_sign(rom[sel_s.idx], sel_s.neg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= sum_next;
            quo_reg   <= quo_next;
            sum_d_reg <= sum_reg;
            ang_reg   <= ang_next;
            cos_reg   <= cos_next;
            sin_reg   <= sin_next;
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

/* sv/rrgc_proj.sv */
module rrgc_proj
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [rrgc_pkg::POS_W-1:0]   pos,
    input  logic [rrgc_pkg::DIST_W-1:0]         span,
    input  logic signed [rrgc_pkg::TRIG_W-1:0]  trig,
    input  logic [rrgc_pkg::CPM_W-1:0]          cells_per_meter,
    output logic signed [rrgc_pkg::CELL_W-1:0]  coord
);

    localparam int F      = rrgc_pkg::TRIG_FRAC_BITS;
    localparam int PROD_W = rrgc_pkg::DIST_W + 1 + rrgc_pkg::TRIG_W;
    localparam int M_W    = rrgc_pkg::POS_W + F + 1;
    localparam int SC_W   = rrgc_pkg::MQ_W + rrgc_pkg::CPM_W + 1;

    logic signed [PROD_W-1:0]            prod_reg, prod_next;
    logic signed [rrgc_pkg::POS_W-1:0]   pos_reg;
    logic signed [rrgc_pkg::MQ_W-1:0]    mq_reg, mq_next;
    logic signed [rrgc_pkg::CELL_W-1:0]  coord_reg, coord_next;

    logic signed [M_W-1:0]  m;
    logic signed [SC_W-1:0] scaled;

    always_comb
    begin
        prod_next = PROD_W'(signed'({1'b0, span})) * PROD_W'(trig);

        // floor by dropping the fraction bits of a two's complement value
        m       = signed'({pos_reg, {F{1'b0}}}) + M_W'(prod_reg);
        mq_next = m[M_W-1:F];

        scaled     = SC_W'(mq_reg) * SC_W'(signed'({1'b0, cells_per_meter}));
        coord_next = scaled[SC_W-1:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            pos_reg   <= pos;
            mq_reg    <= mq_next;
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule
